### design/traffic_size_histogram_assert.svh
// Assertion macros shared by the traffic size histogram design files.
`ifndef TRAFFIC_SIZE_HISTOGRAM_ASSERT_SVH
`define TRAFFIC_SIZE_HISTOGRAM_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TSH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TSH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/tsh_pkg.sv
// Package with the shared widths, codes and control structs of the traffic size histogram.
package tsh_pkg;

    localparam int TRAFFIC_W   = 40;
    localparam int COUNT_W     = 32;
    localparam int SELECT_W    = 10;
    localparam int INDEX_W     = 10;
    localparam int MODE_W      = 2;
    localparam int WIDTH_REG_W = 32;
    localparam int BINS_REG_W  = 11;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 56;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 2;

    // Radix-2 divider: one quotient bit per step.
    localparam int DIV_STEPS = TRAFFIC_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [MODE_W-1:0] MODE_RECORD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_BIN_WIDTH   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BINS_IN_USE = 1'd1;

    typedef struct packed {
        logic busy;
        logic done;
    } tsh_div_stat_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } tsh_mem_cmd_t;

endpackage

### design/traffic_size_histogram.sv
// Top level of the traffic size histogram: stream ports, register file, sequencer and result register.
//
// The block keeps MAX_BINS 32-bit counters in one synchronous memory and handles one
// transfer at a time. A record transfer divides traffic_bytes by bin_width in a radix-2
// divider that produces one quotient bit per cycle; after the divider steps the sequencer
// takes the quotient and picks the bin, then does the memory read, the modify and write
// back, and moves the result into the output register. A read or clear transfer skips the
// divider and starts at the memory read; a read or clear of a bin that is not in use, or
// the unused mode 3, goes straight to the output register and does not touch the memory.
// The next transfer is accepted at the earliest in the cycle after the result is loaded,
// and a result that waits on m_tready holds the sequencer only while the output register
// is still full. The divider latency is what sets the record rate.
// Counters are read, modified and written back strictly in sequence, so two accesses to
// the same bin never overlap. After reset the memory is swept to zero one entry per cycle,
// over all MAX_BINS entries (1024 by default); s_tready stays low during the sweep, while
// configuration writes are accepted as usual. The output register lets a new transfer be
// accepted while the previous result waits on m_tready.
`include "traffic_size_histogram_assert.svh"

module traffic_size_histogram #(
    parameter int MAX_BINS = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: traffic_bytes [39:0], bin_select [49:40], zero [55:50].
    input  logic [tsh_pkg::IN_TDATA_W-1:0]      s_tdata,
    // s_tuser: mode [1:0].
    input  logic [tsh_pkg::IN_TUSER_W-1:0]      s_tuser,
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: bin_index [9:0], bin_value [41:10], zero [47:42].
    output logic [tsh_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // m_tuser: was_clamped [0], bad_select [1].
    output logic [tsh_pkg::OUT_TUSER_W-1:0]     m_tuser,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tsh_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tsh_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import tsh_pkg::*;

    localparam int AW = $clog2(MAX_BINS);
    localparam int NW = $clog2(MAX_BINS + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DIV    = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_MODIFY = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0] state_reg, state_next;

    // Configuration registers.
    logic [WIDTH_REG_W-1:0] bin_width_reg, bin_width_next;
    logic [BINS_REG_W-1:0]  bins_reg, bins_next;

    // Fields of the transfer in progress.
    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [AW-1:0]      addr_reg, addr_next;

    // Staged result, waiting for the output register.
    logic [INDEX_W-1:0] res_idx_reg, res_idx_next;
    logic [COUNT_W-1:0] res_val_reg, res_val_next;
    logic               res_clamp_reg, res_clamp_next;
    logic               res_bad_reg, res_bad_next;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0] out_idx_reg, out_idx_next;
    logic [COUNT_W-1:0] out_val_reg, out_val_next;
    logic               out_clamp_reg, out_clamp_next;
    logic               out_bad_reg, out_bad_next;

    logic [MODE_W-1:0]      in_mode;
    logic [TRAFFIC_W-1:0]   in_bytes;
    logic [SELECT_W-1:0]    in_sel;
    logic                   in_xfer;
    logic                   out_free;
    logic [NW-1:0]          n_bins;
    logic [AW-1:0]          last_bin;
    logic                   sel_bad;
    logic                   q_clamp;
    logic                   div_start;
    logic [WIDTH_REG_W-1:0] divisor;
    tsh_div_stat_t          div_stat;
    logic [TRAFFIC_W-1:0]   div_quo;
    tsh_mem_cmd_t           mem_cmd;
    logic [AW-1:0]          mem_addr;
    logic [COUNT_W-1:0]     mem_wdata;
    logic [COUNT_W-1:0]     mem_rdata;
    logic                   clr_busy;

    assign in_mode  = s_tuser[MODE_W-1:0];
    assign in_bytes = s_tdata[TRAFFIC_W-1:0];
    assign in_sel   = s_tdata[TRAFFIC_W+SELECT_W-1:TRAFFIC_W];

    assign s_tready  = (state_reg == ST_IDLE) && !clr_busy;
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // Active bin count: zero counts as one bin, and the memory depth caps it.
    always_comb
    begin
        if (bins_reg == '0)
        begin
            n_bins = NW'(1);
        end
        else if (32'(bins_reg) > 32'(MAX_BINS))
        begin
            n_bins = NW'(MAX_BINS);
        end
        else
        begin
            n_bins = NW'(bins_reg);
        end
    end

    assign last_bin = AW'(n_bins - NW'(1));
    assign sel_bad  = 32'(in_sel) >= 32'(n_bins);
    // The whole 40-bit quotient is compared, so every large count clamps.
    assign q_clamp  = div_quo >= TRAFFIC_W'(n_bins);
    // A zero bin width divides as a width of one.
    assign divisor  = (bin_width_reg == '0) ? WIDTH_REG_W'(1) : bin_width_reg;

    // Configuration writes.
    always_comb
    begin
        bin_width_next = bin_width_reg;
        bins_next      = bins_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BIN_WIDTH:   bin_width_next = cfg_data[WIDTH_REG_W-1:0];
                CFG_BINS_IN_USE: bins_next      = cfg_data[BINS_REG_W-1:0];
                default:         bins_next      = bins_reg;
            endcase
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        addr_next      = addr_reg;
        res_idx_next   = res_idx_reg;
        res_val_next   = res_val_reg;
        res_clamp_next = res_clamp_reg;
        res_bad_next   = res_bad_reg;
        div_start      = 1'b0;
        mem_cmd.rd_en  = 1'b0;
        mem_cmd.wr_en  = 1'b0;
        mem_addr       = addr_reg;
        mem_wdata      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    mode_next      = in_mode;
                    res_clamp_next = 1'b0;
                    res_bad_next   = 1'b0;
                    case (in_mode) inside
                        MODE_RECORD:
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                        MODE_READ, MODE_CLEAR:
                        begin
                            res_idx_next = INDEX_W'(in_sel);
                            if (sel_bad)
                            begin
                                res_val_next = '0;
                                res_bad_next = 1'b1;
                                state_next   = ST_EMIT;
                            end
                            else
                            begin
                                addr_next  = AW'(in_sel);
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                            // Unused mode: flag it and report nothing else.
                            res_idx_next = '0;
                            res_val_next = '0;
                            res_bad_next = 1'b1;
                            state_next   = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    res_clamp_next = q_clamp;
                    addr_next      = q_clamp ? last_bin : div_quo[AW-1:0];
                    state_next     = ST_READ;
                end
            end
            ST_READ:
            begin
                mem_cmd.rd_en = 1'b1;
                state_next    = ST_MODIFY;
            end
            ST_MODIFY:
            begin
                case (mode_reg)
                    MODE_RECORD:
                    begin
                        mem_cmd.wr_en = 1'b1;
                        mem_wdata     = mem_rdata + COUNT_W'(1);
                    end
                    MODE_CLEAR:
                    begin
                        mem_cmd.wr_en = 1'b1;
                        mem_wdata     = '0;
                    end
                    default:
                    begin
                        mem_wdata = mem_rdata;
                    end
                endcase
                res_val_next = mem_wdata;
                res_idx_next = INDEX_W'(addr_reg);
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: loads from the staged result, drains on m_tready.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_idx_next   = out_idx_reg;
        out_val_next   = out_val_reg;
        out_clamp_next = out_clamp_reg;
        out_bad_next   = out_bad_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == ST_EMIT) && out_free)
        begin
            out_valid_next = 1'b1;
            out_idx_next   = res_idx_reg;
            out_val_next   = res_val_reg;
            out_clamp_next = res_clamp_reg;
            out_bad_next   = res_bad_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bin_width_reg <= WIDTH_REG_W'(1);
            bins_reg      <= BINS_REG_W'(1024);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bin_width_reg <= bin_width_next;
            bins_reg      <= bins_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        addr_reg      <= addr_next;
        res_idx_reg   <= res_idx_next;
        res_val_reg   <= res_val_next;
        res_clamp_reg <= res_clamp_next;
        res_bad_reg   <= res_bad_next;
        out_idx_reg   <= out_idx_next;
        out_val_reg   <= out_val_next;
        out_clamp_reg <= out_clamp_next;
        out_bad_reg   <= out_bad_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - COUNT_W - INDEX_W)'(0), out_val_reg, out_idx_reg};
    assign m_tuser  = {out_bad_reg, out_clamp_reg};

    tsh_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (in_bytes),
        .divisor  (divisor),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    tsh_bins #(
        .MAX_BINS (MAX_BINS)
    ) u_bins (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (mem_cmd),
        .addr     (mem_addr),
        .wdata    (mem_wdata),
        .rdata    (mem_rdata),
        .clr_busy (clr_busy)
    );

    // No transfer is taken while the clearing pass still owns the memory.
    `TSH_ASSERT_NOW(a_no_accept_in_clear, s_tready, !clr_busy,
        "input accepted during the clearing pass")
    // The divider only finishes while the sequencer waits for it.
    `TSH_ASSERT_NOW(a_div_done_in_div, div_stat.done, state_reg == ST_DIV,
        "divider finished outside the divide state")
    // A record transfer always starts the divider.
    `TSH_ASSERT_NEXT(a_record_divides, in_xfer && (in_mode == MODE_RECORD),
        (state_reg == ST_DIV) && div_stat.busy, "record transfer did not start the divider")
    // A flagged result never carries a count.
    `TSH_ASSERT_NOW(a_bad_has_zero, m_tvalid && m_tuser[1],
        (m_tdata[41:10] == 32'd0) && !m_tuser[0], "flagged result carries a count")

endmodule

### design/tsh_div.sv
// Iterative restoring divider of the byte count by the bin width, one quotient bit per cycle.
module tsh_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tsh_pkg::TRAFFIC_W-1:0] dividend,
    input  logic [tsh_pkg::WIDTH_REG_W-1:0] divisor,
    output tsh_pkg::tsh_div_stat_t        stat,
    output logic [tsh_pkg::TRAFFIC_W-1:0] quotient
);
    import tsh_pkg::*;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [TRAFFIC_W-1:0]   quo_reg, quo_next;
    logic [WIDTH_REG_W-1:0] rem_reg, rem_next;
    logic [WIDTH_REG_W-1:0] dsr_reg, dsr_next;
    logic [WIDTH_REG_W:0]   trial;
    logic                   fits;

    // The dividend shifts out of the top of quo_reg while quotient bits enter at the bottom.
    assign trial = {rem_reg, quo_reg[TRAFFIC_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[TRAFFIC_W-2:0], fits};
            if (fits)
            begin
                rem_next = WIDTH_REG_W'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = trial[WIDTH_REG_W-1:0];
            end
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

### design/tsh_bins.sv
// Bin counter memory with a registered read port and the clearing pass after reset.
module tsh_bins #(
    parameter int MAX_BINS = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tsh_pkg::tsh_mem_cmd_t           cmd,
    input  logic [$clog2(MAX_BINS)-1:0]     addr,
    input  logic [tsh_pkg::COUNT_W-1:0]     wdata,
    output logic [tsh_pkg::COUNT_W-1:0]     rdata,
    output logic                            clr_busy
);
    import tsh_pkg::*;

    localparam int AW = $clog2(MAX_BINS);

    logic [COUNT_W-1:0] counts_mem [MAX_BINS];
    logic [COUNT_W-1:0] rdata_reg;
    logic               clr_busy_reg, clr_busy_next;
    logic [AW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic               we;
    logic [AW-1:0]      wa;
    logic [COUNT_W-1:0] wd;

    // The sweep owns the write port until every entry holds zero.
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == AW'(MAX_BINS - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
        we = clr_busy_reg | cmd.wr_en;
        wa = clr_busy_reg ? clr_cnt_reg : addr;
        wd = clr_busy_reg ? '0 : wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            counts_mem[wa] <= wd;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= counts_mem[addr];
        end
    end

    assign rdata    = rdata_reg;
    assign clr_busy = clr_busy_reg;

endmodule

### bench/tb_traffic_size_histogram.sv
// Self-checking testbench for the traffic size histogram: a directed table, then random phases.
`timescale 1ns / 100ps

module tb_traffic_size_histogram;
    import tsh_pkg::*;

    localparam int NUM_BINS    = 1024;
    localparam int IDLE_LIMIT  = 6000;  // covers the clearing sweep after reset several times
    localparam int TAIL_CYCLES = 64;    // outlasts a record from acceptance to result
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 160;

    // Mode 3 has no operation behind it; the block answers with bad_select alone.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // One result transfer, field by field.
    typedef struct packed {
        logic [INDEX_W-1:0] idx;
        logic [COUNT_W-1:0] value;
        logic               clamped;
        logic               bad;
    } bin_report_t;

    // One row of the directed table: either a register write or an input transfer.
    typedef struct {
        logic                   is_cfg;
        logic [CFG_INDEX_W-1:0] reg_sel;
        logic [CFG_DATA_W-1:0]  reg_val;
        logic [MODE_W-1:0]      mode;
        logic [TRAFFIC_W-1:0]   bytes;
        logic [SELECT_W-1:0]    sel;
        logic                   typed;
        bin_report_t            want;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Travels with s_tdata: a hand-typed expectation for the transfer being offered.
    logic        row_typed = 1'b0;
    bin_report_t row_want = '0;

    // Our own copy of the histogram and its registers, advanced on every accepted transfer.
    logic [COUNT_W-1:0]    tally [NUM_BINS];
    logic [WIDTH_REG_W-1:0] width_reg;
    logic [BINS_REG_W-1:0] bins_reg;

    bin_report_t bin_results_due [$];
    stim_row_t   directed_rows [$];

    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int gap_pct = 0;
    bit wind_down = 1'b0;
    int n_records = 0;
    int n_reads = 0;
    int n_clears = 0;
    int n_unused = 0;
    int n_clamped = 0;
    int n_bad = 0;
    int n_reg_writes = 0;

    always #4 clk = ~clk;

    traffic_size_histogram #(
        .MAX_BINS (NUM_BINS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    task automatic log_error(input string what);
        errors++;
        $display("[%0t] ERROR %s", $time, what);
    endtask

    // A bins_in_use of zero means one bin, and anything above the store size means all of it.
    function automatic int unsigned live_bins(input logic [BINS_REG_W-1:0] b);
        int unsigned n;
        n = 32'(b);
        if (n == 0)
            n = 1;
        if (n > NUM_BINS)
            n = NUM_BINS;
        return n;
    endfunction

    // Applies one input transfer to the local histogram and returns the result it must produce.
    function automatic bin_report_t histogram_update(input logic [MODE_W-1:0] mode,
                                                     input logic [TRAFFIC_W-1:0] bytes,
                                                     input logic [SELECT_W-1:0] sel);
        bin_report_t r;
        logic [63:0] w;
        logic [63:0] q;
        int unsigned n;
        r = '0;
        n = live_bins(bins_reg);
        case (mode) inside
            MODE_RECORD:
            begin
                // A zero width acts as one; the whole quotient is compared, so huge counts clamp.
                w = (width_reg == 0) ? 64'd1 : 64'(width_reg);
                q = 64'(bytes) / w;
                if (q >= 64'(n))
                begin
                    r.idx     = INDEX_W'(n - 1);
                    r.clamped = 1'b1;
                end
                else
                begin
                    r.idx = q[INDEX_W-1:0];
                end
                tally[r.idx] = tally[r.idx] + 1'b1;
                r.value      = tally[r.idx];
            end
            MODE_READ, MODE_CLEAR:
            begin
                r.idx = sel;
                if (sel >= n)
                begin
                    r.bad = 1'b1;
                end
                else
                begin
                    if (mode == MODE_CLEAR)
                        tally[sel] = '0;
                    r.value = tally[sel];
                end
            end
            default:
            begin
                r.bad = 1'b1;
            end
        endcase
        return r;
    endfunction

    task automatic table_item(input logic [MODE_W-1:0] mode, input logic [TRAFFIC_W-1:0] bytes,
                              input logic [SELECT_W-1:0] sel);
        stim_row_t row;
        row         = '{default: '0};
        row.mode    = mode;
        row.bytes   = bytes;
        row.sel     = sel;
        directed_rows.push_back(row);
    endtask

    task automatic table_check(input logic [MODE_W-1:0] mode, input logic [TRAFFIC_W-1:0] bytes,
                               input logic [SELECT_W-1:0] sel, input logic [INDEX_W-1:0] idx,
                               input logic [COUNT_W-1:0] value, input logic clamped,
                               input logic bad);
        stim_row_t row;
        row         = '{default: '0};
        row.mode    = mode;
        row.bytes   = bytes;
        row.sel     = sel;
        row.typed   = 1'b1;
        row.want    = '{idx: idx, value: value, clamped: clamped, bad: bad};
        directed_rows.push_back(row);
    endtask

    task automatic table_cfg(input logic [CFG_INDEX_W-1:0] reg_sel,
                             input logic [CFG_DATA_W-1:0] reg_val);
        stim_row_t row;
        row         = '{default: '0};
        row.is_cfg  = 1'b1;
        row.reg_sel = reg_sel;
        row.reg_val = reg_val;
        directed_rows.push_back(row);
    endtask

    // Offers one input transfer, at times after a random gap, and returns at the edge that accepts it.
    // Valid is left high so that a back-to-back transfer needs no second assignment.
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [TRAFFIC_W-1:0] bytes,
                             input logic [SELECT_W-1:0] sel, input logic typed,
                             input bin_report_t want);
        cfg_valid <= 1'b0;
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tuser   <= mode;
        s_tdata   <= {{(IN_TDATA_W - TRAFFIC_W - SELECT_W){1'b0}}, sel, bytes};
        row_typed <= typed;
        row_want  <= want;
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    // Register writes happen only once every outstanding result has come back.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] reg_sel,
                             input logic [CFG_DATA_W-1:0] reg_val);
        s_tvalid <= 1'b0;
        while (results_seen != items_sent)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= reg_sel;
        cfg_data  <= reg_val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Monitor: checks results first, then predicts, so a result and a new transfer accepted
    // at the same edge never pair up with each other.
    always @(posedge clk)
    begin
        bin_report_t got;
        bin_report_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.idx     = m_tdata[INDEX_W-1:0];
                got.value   = m_tdata[INDEX_W +: COUNT_W];
                got.clamped = m_tuser[0];
                got.bad     = m_tuser[1];
                results_seen++;
                if (bin_results_due.size() == 0)
                begin
                    log_error($sformatf("result for bin %0d with nothing outstanding", got.idx));
                end
                else
                begin
                    want = bin_results_due.pop_front();
                    if (got.idx !== want.idx)
                        log_error($sformatf("result %0d bin_index %0d, want %0d",
                                            results_seen, got.idx, want.idx));
                    if (got.value !== want.value)
                        log_error($sformatf("result %0d bin_value %0d, want %0d",
                                            results_seen, got.value, want.value));
                    if (got.clamped !== want.clamped)
                        log_error($sformatf("result %0d was_clamped %b, want %b",
                                            results_seen, got.clamped, want.clamped));
                    if (got.bad !== want.bad)
                        log_error($sformatf("result %0d bad_select %b, want %b",
                                            results_seen, got.bad, want.bad));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                n_reg_writes++;
                if (cfg_index == CFG_BIN_WIDTH)
                    width_reg = cfg_data;
                else
                    bins_reg = cfg_data[BINS_REG_W-1:0];
            end
            if (s_tvalid && s_tready)
            begin
                want = histogram_update(s_tuser, s_tdata[TRAFFIC_W-1:0],
                                        s_tdata[TRAFFIC_W +: SELECT_W]);
                if (row_typed)
                    want = row_want;
                case (s_tuser)
                    MODE_RECORD: n_records++;
                    MODE_READ:   n_reads++;
                    MODE_CLEAR:  n_clears++;
                    default:     n_unused++;
                endcase
                if (want.clamped)
                    n_clamped++;
                if (want.bad)
                    n_bad++;
                bin_results_due.push_back(want);
            end
        end
    end

    // Result side: ready drops at random, never once the run winds down.
    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!wind_down && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    // Watchdog: ends the run when no channel has moved a transfer for too long.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        wait (rst_n === 1'b1);
        while (quiet_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[%0t] watchdog: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        logic [CFG_DATA_W-1:0]  w_cfg;
        logic [CFG_DATA_W-1:0]  b_cfg;
        logic [63:0]            w_eff;
        int unsigned            n_eff;
        logic [63:0]            span;
        logic [63:0]            raw;
        logic [MODE_W-1:0]      mode;
        logic [TRAFFIC_W-1:0]   bytes;
        logic [SELECT_W-1:0]    sel;
        int                     pick;

        // Local copy of the reset state.
        width_reg = 32'd1;
        bins_reg  = BINS_REG_W'(NUM_BINS);
        foreach (tally[i])
            tally[i] = '0;

        // Reset values: width 1, all 1024 bins.
        table_check(MODE_READ,   40'd0,             10'd0,    10'd0,    32'd0, 1'b0, 1'b0);
        table_check(MODE_READ,   40'd0,             10'd1023, 10'd1023, 32'd0, 1'b0, 1'b0);
        table_check(MODE_RECORD, 40'd0,             10'd0,    10'd0,    32'd1, 1'b0, 1'b0);
        table_check(MODE_RECORD, 40'd1023,          10'd0,    10'd1023, 32'd1, 1'b0, 1'b0);
        table_check(MODE_RECORD, 40'd1024,          10'd0,    10'd1023, 32'd2, 1'b1, 1'b0);
        table_check(MODE_RECORD, 40'hFF_FFFF_FFFF,  10'd0,    10'd1023, 32'd3, 1'b1, 1'b0);
        table_check(MODE_CLEAR,  40'd0,             10'd1023, 10'd1023, 32'd0, 1'b0, 1'b0);
        table_check(MODE_UNUSED, 40'hFF_FFFF_FFFF,  10'd1023, 10'd0,    32'd0, 1'b0, 1'b1);
        // Zero width acts as one and zero bins act as a single bin.
        table_cfg(CFG_BIN_WIDTH,   32'd0);
        table_cfg(CFG_BINS_IN_USE, 32'd0);
        table_check(MODE_RECORD, 40'd0,             10'd0,    10'd0,    32'd2, 1'b0, 1'b0);
        table_check(MODE_RECORD, 40'd1,             10'd0,    10'd0,    32'd3, 1'b1, 1'b0);
        table_check(MODE_READ,   40'd0,             10'd1,    10'd1,    32'd0, 1'b0, 1'b1);
        table_check(MODE_CLEAR,  40'd0,             10'd1023, 10'd1023, 32'd0, 1'b0, 1'b1);
        table_check(MODE_READ,   40'd0,             10'd0,    10'd0,    32'd3, 1'b0, 1'b0);
        table_check(MODE_CLEAR,  40'd0,             10'd0,    10'd0,    32'd0, 1'b0, 1'b0);
        // Widest bins, and a bin count above the store size.
        table_cfg(CFG_BIN_WIDTH,   32'hFFFF_FFFF);
        table_cfg(CFG_BINS_IN_USE, 32'd2047);
        table_check(MODE_RECORD, 40'hFF_FFFF_FFFF,  10'd0,    10'd256,  32'd1, 1'b0, 1'b0);
        table_item(MODE_RECORD,  40'hFF_FFFF_FF00,  10'd0);
        table_item(MODE_RECORD,  40'hFF_FFFF_FEFF,  10'd0);
        table_check(MODE_READ,   40'd0,             10'd1023, 10'd1023, 32'd0, 1'b0, 1'b0);
        // Small histogram: edges of the last bin and a select just past it.
        table_cfg(CFG_BIN_WIDTH,   32'd1000);
        table_cfg(CFG_BINS_IN_USE, 32'd5);
        table_item(MODE_RECORD,  40'd4999,          10'd0);
        table_item(MODE_RECORD,  40'd5000,          10'd0);
        table_check(MODE_READ,   40'd0,             10'd5,    10'd5,    32'd0, 1'b0, 1'b1);
        table_item(MODE_CLEAR,   40'd0,             10'd4);
        table_item(MODE_READ,    40'd0,             10'd4);
        table_check(MODE_UNUSED, 40'd0,             10'd0,    10'd0,    32'd0, 1'b0, 1'b1);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        gap_pct = 25;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                write_reg(directed_rows[i].reg_sel, directed_rows[i].reg_val);
            else
                send_item(directed_rows[i].mode, directed_rows[i].bytes, directed_rows[i].sel,
                          directed_rows[i].typed, directed_rows[i].want);
        end

        // Random phases. The first few pin the register extremes; later ones draw them.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin w_cfg = 32'd1;           b_cfg = 32'd1024; end
                1: begin w_cfg = 32'hFFFF_FFFF;   b_cfg = 32'd1024; end
                2: begin w_cfg = 32'd0;           b_cfg = 32'd2;    end
                3: begin w_cfg = 32'd7;           b_cfg = 32'd1;    end
                4: begin w_cfg = 32'd1 << $urandom_range(0, 31); b_cfg = 32'd2047; end
                5: begin w_cfg = 32'd1000;        b_cfg = 32'd0;    end
                default:
                begin
                    case ($urandom_range(0, 3))
                        0:       w_cfg = $urandom();
                        1:       w_cfg = 32'd1 << $urandom_range(0, 31);
                        default: w_cfg = $urandom_range(1, 3000);
                    endcase
                    // Upper data bits are random too; only the low eleven bits count.
                    if ($urandom_range(0, 3) == 0)
                        b_cfg = $urandom();
                    else
                        b_cfg = {21'($urandom_range(0, 2097151)),
                                 11'($urandom_range(1, 1024))};
                end
            endcase
            if (p == PHASES - 1)
            begin
                wind_down = 1'b1;
                gap_pct   = 0;
            end
            else
            begin
                gap_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 15 : 35);
            end
            write_reg(CFG_BIN_WIDTH, w_cfg);
            write_reg(CFG_BINS_IN_USE, b_cfg);
            w_eff = (w_cfg == 0) ? 64'd1 : 64'(w_cfg);
            n_eff = live_bins(b_cfg[BINS_REG_W-1:0]);

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                raw   = {$urandom(), $urandom()};
                bytes = raw[TRAFFIC_W-1:0];
                sel   = SELECT_W'($urandom_range(0, NUM_BINS - 1));
                pick  = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    mode = MODE_RECORD;
                    case ($urandom_range(0, 9)) inside
                        [0:5]:
                        begin
                            // Aim at a bin, a little past the end now and then.
                            span  = 64'($urandom_range(0, n_eff + n_eff / 8 + 1)) * w_eff
                                    + ({$urandom(), $urandom()} % w_eff);
                            bytes = span[TRAFFIC_W-1:0];
                        end
                        6, 7:
                        begin
                            bytes = bytes >> $urandom_range(0, TRAFFIC_W - 1);
                        end
                        8:
                        begin
                            // Right at the boundary of the last bin.
                            span  = 64'(n_eff) * w_eff - 64'($urandom_range(0, 1));
                            bytes = span[TRAFFIC_W-1:0];
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else
                begin
                    if (pick < 80)
                        mode = MODE_READ;
                    else if (pick < 95)
                        mode = MODE_CLEAR;
                    else
                        mode = MODE_UNUSED;
                    if ($urandom_range(0, 3) != 0)
                        sel = SELECT_W'($urandom_range(0, n_eff - 1));
                end
                send_item(mode, bytes, sel, 1'b0, '0);
            end
        end

        cfg_valid <= 1'b0;
        s_tvalid  <= 1'b0;
        while (results_seen != items_sent)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (bin_results_due.size() != 0)
            log_error($sformatf("%0d results never arrived", bin_results_due.size()));

        $display("Covered %0d transfers: %0d records, %0d reads, %0d clears, %0d unused mode.",
                 items_sent, n_records, n_reads, n_clears, n_unused);
        $display("%0d register writes, %0d clamped records, %0d bad selects, %0d errors.",
                 n_reg_writes, n_clamped, n_bad, errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
